@@ hdl/mrfp_pkg.sv @@
// Shared types, constants and the byte-wise CRC-16 update for the motor
// response frame parser. No dependencies.
`default_nettype none

package mrfp_pkg;

    // CRC-16/KERMIT, reflected polynomial, zero initial value
    localparam logic [15:0] CRC_POLY = 16'h8408;

    // Header bytes
    localparam logic [7:0] HDR0 = 8'hFD;
    localparam logic [7:0] HDR1 = 8'hEE;

    // Byte positions inside a frame
    localparam int POS_HDR0   = 0;
    localparam int POS_HDR1   = 1;
    localparam int POS_FIELD0 = 2;   // first captured field byte (id / status)
    localparam int NUM_FIELDS = 12;  // bytes 2..13

    // Word held in the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } stage_t;

    // Decoded result word
    typedef struct packed {
        logic               frame_ok;
        logic [3:0]         drive_id;
        logic [2:0]         motor_status;
        logic signed [15:0] torque_q8;
        logic signed [15:0] speed_val;
        logic signed [31:0] angle_val;
        logic signed [7:0]  temperature;
        logic [2:0]         fault_code;
        logic [11:0]        force_val;
    } result_t;

    // One byte through the reflected CRC, unrolled over eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/mrfp_if.sv @@
// Valid/ready channel interfaces for received bytes and decoded results.
// No dependencies.
`default_nettype none

interface mrfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfp_res_if;
    logic               valid;
    logic               ready;
    logic               frame_ok;
    logic [3:0]         drive_id;
    logic [2:0]         motor_status;
    logic signed [15:0] torque_q8;
    logic signed [15:0] speed_val;
    logic signed [31:0] angle_val;
    logic signed [7:0]  temperature;
    logic [2:0]         fault_code;
    logic [11:0]        force_val;

    modport source (
        output valid, output frame_ok, output drive_id, output motor_status,
        output torque_q8, output speed_val, output angle_val,
        output temperature, output fault_code, output force_val,
        input ready
    );
    modport sink (
        input valid, input frame_ok, input drive_id, input motor_status,
        input torque_q8, input speed_val, input angle_val,
        input temperature, input fault_code, input force_val,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/mrfp_rx_stage.sv @@
// Input register for received bytes; refills whenever the core consumes.
// Depends on mrfp_pkg and mrfp_if.
`default_nettype none

module mrfp_rx_stage (
    input  wire              clk,
    input  wire              rst_n,
    mrfp_rx_if.sink          rx,
    input  wire              take,
    output mrfp_pkg::stage_t stage
);
    import mrfp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       load;

    // Accept a new word when empty or when the held word leaves this cycle
    assign rx.ready   = !valid_reg || take;
    assign load       = rx.valid && rx.ready;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data  = data_reg;

endmodule

`default_nettype wire

@@ hdl/mrfp_frame_core.sv @@
// Frame counter, running CRC, field capture and result register.
// Depends on mrfp_pkg and mrfp_if.
`default_nettype none

module mrfp_frame_core #(
    parameter int FRAME_BYTES = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  mrfp_pkg::stage_t stage,
    output logic             take,
    mrfp_res_if.source       res
);
    import mrfp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_BYTES);

    logic [CNT_W-1:0] cnt_reg;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_upd;
    logic             hdr0_ok_reg;
    logic             hdr1_ok_reg;
    logic [7:0]       crc_lo_reg;
    logic [7:0]       field_reg [NUM_FIELDS];
    logic             res_valid_reg;
    result_t          res_reg;
    result_t          res_next;
    logic             is_last;
    logic             in_crc;
    logic             out_free;
    logic             ok;
    logic [15:0]      stat_word;

    assign is_last  = cnt_reg == CNT_W'(FRAME_BYTES - 1);
    assign in_crc   = cnt_reg < CNT_W'(FRAME_BYTES - 2);
    assign out_free = !res_valid_reg || res.ready;

    // Mid-frame bytes always move on; the last one needs a free result slot
    assign take    = stage.valid && (!is_last || out_free);
    assign crc_upd = crc16_byte(crc_reg, stage.data);

    // Byte counter and running CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            crc_reg <= '0;
        end
        else if (take)
        begin
            if (is_last)
            begin
                cnt_reg <= '0;
                crc_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (in_crc)
                begin
                    crc_reg <= crc_upd;
                end
            end
        end
    end

    // Header checks and CRC low byte, captured at their fixed positions
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (cnt_reg == CNT_W'(POS_HDR0))
            begin
                hdr0_ok_reg <= stage.data == HDR0;
            end
            if (cnt_reg == CNT_W'(POS_HDR1))
            begin
                hdr1_ok_reg <= stage.data == HDR1;
            end
            if (cnt_reg == CNT_W'(FRAME_BYTES - 2))
            begin
                crc_lo_reg <= stage.data;
            end
        end
    end

    // Field bytes 2..13, one register each
    for (genvar i = 0; i < NUM_FIELDS; i++)
    begin : g_field
        always_ff @(posedge clk)
        begin
            if (take && cnt_reg == CNT_W'(POS_FIELD0 + i))
            begin
                field_reg[i] <= stage.data;
            end
        end
    end

    // Decode; the last byte is the CRC high byte
    assign ok = hdr0_ok_reg && hdr1_ok_reg && ({stage.data, crc_lo_reg} == crc_reg);
    assign stat_word = {field_reg[11], field_reg[10]};

    always_comb
    begin
        res_next = '0;
        if (ok)
        begin
            res_next.frame_ok     = 1'b1;
            res_next.drive_id     = field_reg[0][3:0];
            res_next.motor_status = field_reg[0][6:4];
            res_next.torque_q8    = {field_reg[2], field_reg[1]};
            res_next.speed_val    = {field_reg[4], field_reg[3]};
            res_next.angle_val    = {field_reg[8], field_reg[7], field_reg[6], field_reg[5]};
            res_next.temperature  = field_reg[9];
            res_next.fault_code   = stat_word[2:0];
            res_next.force_val    = stat_word[14:3];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take && is_last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && is_last)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.frame_ok     = res_reg.frame_ok;
    assign res.drive_id     = res_reg.drive_id;
    assign res.motor_status = res_reg.motor_status;
    assign res.torque_q8    = res_reg.torque_q8;
    assign res.speed_val    = res_reg.speed_val;
    assign res.angle_val    = res_reg.angle_val;
    assign res.temperature  = res_reg.temperature;
    assign res.fault_code   = res_reg.fault_code;
    assign res.force_val    = res_reg.force_val;

endmodule

`default_nettype wire

@@ hdl/motor_response_frame_parser_unit.sv @@
// Top level of the motor response frame parser.
// Depends on mrfp_pkg, mrfp_if, mrfp_rx_stage and mrfp_frame_core.
//
//   channel | dir | word                      | handshake
//   --------+-----+---------------------------+-------------
//   rx      | in  | rx_byte (one frame byte)  | valid/ready
//   res     | out | decoded frame fields      | valid/ready
//
// One byte per cycle sustained; a byte passes the input register and then the
// CRC/field logic, and the result register is loaded as the last byte of a frame
// is taken from the input register. The input stalls only when a finished result
// is still unread as the next frame's last byte arrives. Reset (rst_n, async,
// active low) clears the byte count, CRC and both valid flags; no clearing pass.
`default_nettype none

module motor_response_frame_parser_unit #(
    parameter int FRAME_BYTES = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    mrfp_rx_if.sink    rx,
    mrfp_res_if.source res
);
    import mrfp_pkg::*;

    stage_t stage;
    logic   take;

    mrfp_rx_stage u_rx_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .take  (take),
        .stage (stage)
    );

    mrfp_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_core (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .res   (res)
    );

endmodule

`default_nettype wire
